>>> src/assert_macros.svh
// assertion macros shared by the timer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(lbl, ante, cons)

`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> src/tmr3_pkg.sv
// types and constants of the three-channel reload down timer
package tmr3_pkg;

    localparam int NUM_TIMERS  = 3;
    localparam int COUNT_WIDTH = 32;
    localparam int DATA_WIDTH  = 32;
    localparam int USER_WIDTH  = 6;

    localparam int BIT_ST = 0;
    localparam int BIT_AR = 1;
    localparam int BIT_CE = 5;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        SEL_CNTL  = 2'd0,
        SEL_LOAD  = 2'd1,
        SEL_COUNT = 2'd2
    } sel_t;

    typedef logic [COUNT_WIDTH-1:0] count_t;

endpackage

>>> src/three_channel_reload_down_timer_unit.sv
// Three 32-bit auto-reload down timers behind a register interface. Each input
// item is a tick or a register access; ticks and unused op codes give no result,
// reads and writes give one output item each (read data, or the write data echoed).
// The block takes one item per cycle while no result is held back: an item waits in
// the input register, is applied to the timer state by combinational logic, and its
// result lands in the output register as the item is applied.
// While a result waits on a stalled output, a read or write held in the input
// register waits too and holds back every item behind it; a tick there still proceeds.
`include "assert_macros.svh"

module three_channel_reload_down_timer_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // write_data
    input  logic [tmr3_pkg::DATA_WIDTH-1:0] s_axis_tdata,
    // op [1:0], unit_index [3:2], reg_select [5:4]
    input  logic [tmr3_pkg::USER_WIDTH-1:0] s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // read_data
    output logic [tmr3_pkg::DATA_WIDTH-1:0] m_axis_tdata
);

    // input register
    logic                            in_valid_reg;
    tmr3_pkg::op_t                   in_op_reg;
    logic [1:0]                      in_unit_reg;
    tmr3_pkg::sel_t                  in_sel_reg;
    logic [tmr3_pkg::DATA_WIDTH-1:0] in_data_reg;

    // output register
    logic                            out_valid_reg;
    logic [tmr3_pkg::DATA_WIDTH-1:0] out_data_reg;
    logic [tmr3_pkg::DATA_WIDTH-1:0] out_data_next;

    // timer state
    logic [tmr3_pkg::DATA_WIDTH-1:0] ctrl_reg   [tmr3_pkg::NUM_TIMERS];
    logic [tmr3_pkg::DATA_WIDTH-1:0] ctrl_next  [tmr3_pkg::NUM_TIMERS];
    logic                            start_reg  [tmr3_pkg::NUM_TIMERS];
    logic                            start_next [tmr3_pkg::NUM_TIMERS];
    logic                            reload_reg [tmr3_pkg::NUM_TIMERS];
    logic                            reload_next[tmr3_pkg::NUM_TIMERS];
    logic                            enable_reg [tmr3_pkg::NUM_TIMERS];
    logic                            enable_next[tmr3_pkg::NUM_TIMERS];
    tmr3_pkg::count_t                count_reg  [tmr3_pkg::NUM_TIMERS];
    tmr3_pkg::count_t                count_next [tmr3_pkg::NUM_TIMERS];
    tmr3_pkg::count_t                load_reg   [tmr3_pkg::NUM_TIMERS];
    tmr3_pkg::count_t                load_next  [tmr3_pkg::NUM_TIMERS];

    logic has_result;
    logic out_free;
    logic proc_fire;

    assign has_result    = (in_op_reg == tmr3_pkg::OP_READ) || (in_op_reg == tmr3_pkg::OP_WRITE);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proc_fire     = in_valid_reg && (!has_result || out_free);
    assign s_axis_tready = !in_valid_reg || proc_fire;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg   <= tmr3_pkg::op_t'(s_axis_tuser[1:0]);
            in_unit_reg <= s_axis_tuser[3:2];
            in_sel_reg  <= tmr3_pkg::sel_t'(s_axis_tuser[5:4]);
            in_data_reg <= s_axis_tdata;
        end
    end

    // state update and result for the registered item
    always_comb
    begin
        out_data_next = in_data_reg;
        for (int u = 0; u < tmr3_pkg::NUM_TIMERS; u++)
        begin
            ctrl_next[u]   = ctrl_reg[u];
            start_next[u]  = start_reg[u];
            reload_next[u] = reload_reg[u];
            enable_next[u] = enable_reg[u];
            count_next[u]  = count_reg[u];
            load_next[u]   = load_reg[u];
        end
        case (in_op_reg)
            tmr3_pkg::OP_TICK:
            begin
                for (int u = 0; u < tmr3_pkg::NUM_TIMERS; u++)
                begin
                    if (start_reg[u] || enable_reg[u])
                    begin
                        if (count_reg[u] == '0)
                        begin
                            if (reload_reg[u])
                            begin
                                count_next[u] = load_reg[u] - 1'b1;
                            end
                            else
                            begin
                                start_next[u] = 1'b0;
                            end
                        end
                        else
                        begin
                            count_next[u] = count_reg[u] - 1'b1;
                        end
                    end
                end
            end
            tmr3_pkg::OP_READ:
            begin
                out_data_next = '0;
                for (int u = 0; u < tmr3_pkg::NUM_TIMERS; u++)
                begin
                    if (u == int'(in_unit_reg))
                    begin
                        case (in_sel_reg)
                            tmr3_pkg::SEL_CNTL:  out_data_next = ctrl_reg[u];
                            tmr3_pkg::SEL_LOAD:  out_data_next = 32'(load_reg[u]);
                            tmr3_pkg::SEL_COUNT: out_data_next = 32'(count_reg[u]);
                            default:             out_data_next = '0;
                        endcase
                    end
                end
            end
            tmr3_pkg::OP_WRITE:
            begin
                for (int u = 0; u < tmr3_pkg::NUM_TIMERS; u++)
                begin
                    if (u == int'(in_unit_reg))
                    begin
                        case (in_sel_reg)
                            tmr3_pkg::SEL_CNTL:
                            begin
                                ctrl_next[u]   = in_data_reg;
                                start_next[u]  = in_data_reg[tmr3_pkg::BIT_ST];
                                reload_next[u] = in_data_reg[tmr3_pkg::BIT_AR];
                                enable_next[u] = in_data_reg[tmr3_pkg::BIT_CE];
                                if (in_data_reg[tmr3_pkg::BIT_ST] && !start_reg[u])
                                begin
                                    count_next[u] = load_reg[u];
                                end
                            end
                            tmr3_pkg::SEL_LOAD:
                            begin
                                load_next[u] = in_data_reg[tmr3_pkg::COUNT_WIDTH-1:0];
                            end
                            default:
                            begin
                                load_next[u] = load_reg[u];
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                out_data_next = in_data_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int u = 0; u < tmr3_pkg::NUM_TIMERS; u++)
            begin
                ctrl_reg[u]   <= '0;
                start_reg[u]  <= 1'b0;
                reload_reg[u] <= 1'b0;
                enable_reg[u] <= 1'b0;
                count_reg[u]  <= '0;
                load_reg[u]   <= '0;
            end
        end
        else if (proc_fire)
        begin
            for (int u = 0; u < tmr3_pkg::NUM_TIMERS; u++)
            begin
                ctrl_reg[u]   <= ctrl_next[u];
                start_reg[u]  <= start_next[u];
                reload_reg[u] <= reload_next[u];
                enable_reg[u] <= enable_next[u];
                count_reg[u]  <= count_next[u];
                load_reg[u]   <= load_next[u];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_fire && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && has_result)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // result-producing item never overwrites a waiting result
    `ASSERT_SAME(a_no_overwrite,
        in_valid_reg && has_result && out_valid_reg && !m_axis_tready, !proc_fire)

    // a tick or unused op leaves the output side alone
    `ASSERT_NEXT(a_tick_no_result,
        proc_fire && !has_result, out_valid_reg == $past(out_valid_reg && !m_axis_tready))

    // one-shot unit zero stops at zero
    `ASSERT_NEXT(a_one_shot_stop,
        proc_fire && in_op_reg == tmr3_pkg::OP_TICK && start_reg[0] && !reload_reg[0]
            && count_reg[0] == '0, !start_reg[0])

    // starting unit zero copies the load value into the count
    `ASSERT_NEXT(a_start_loads,
        proc_fire && in_op_reg == tmr3_pkg::OP_WRITE && in_sel_reg == tmr3_pkg::SEL_CNTL
            && in_unit_reg == 2'd0 && in_data_reg[tmr3_pkg::BIT_ST] && !start_reg[0],
        count_reg[0] == $past(load_reg[0]))

endmodule

>>> dv/timer_register_checker.sv
// checker: predicts timer register results and compares them with the output stream
module timer_register_checker
    import tmr3_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // write_data
    input  logic [DATA_WIDTH-1:0] s_axis_tdata,
    // op [1:0], unit_index [3:2], reg_select [5:4]
    input  logic [USER_WIDTH-1:0] s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // read_data
    input  logic [DATA_WIDTH-1:0] m_axis_tdata,
    output int                    mismatches,
    output int                    pending,
    output int                    results_checked
);

    logic [DATA_WIDTH-1:0] ctrl_word [NUM_TIMERS];
    logic                  run_on [NUM_TIMERS];
    logic                  auto_reload [NUM_TIMERS];
    logic                  clk_en [NUM_TIMERS];
    count_t                count_now [NUM_TIMERS];
    count_t                reload_val [NUM_TIMERS];
    logic [DATA_WIDTH-1:0] due_read_data [$];
    int                    error_total = 0;
    int                    checked_total = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_total++;
    endtask

    task automatic clear_timers();
        for (int u = 0; u < NUM_TIMERS; u++)
        begin
            ctrl_word[u]   = '0;
            run_on[u]      = 1'b0;
            auto_reload[u] = 1'b0;
            clk_en[u]      = 1'b0;
            count_now[u]   = '0;
            reload_val[u]  = '0;
        end
    endtask

    task automatic tick_timers();
        for (int u = 0; u < NUM_TIMERS; u++)
        begin
            if (run_on[u] || clk_en[u])
            begin
                if (count_now[u] == '0)
                begin
                    if (auto_reload[u])
                        count_now[u] = reload_val[u] - 1'b1;
                    else
                        run_on[u] = 1'b0;
                end
                else
                begin
                    count_now[u] = count_now[u] - 1'b1;
                end
            end
        end
    endtask

    task automatic write_control(input int u, input logic [DATA_WIDTH-1:0] word);
        logic was_running;
        was_running    = run_on[u];
        run_on[u]      = word[BIT_ST];
        auto_reload[u] = word[BIT_AR];
        clk_en[u]      = word[BIT_CE];
        ctrl_word[u]   = word;
        if (run_on[u] && !was_running)
            count_now[u] = reload_val[u];
    endtask

    task automatic apply_item(input logic [USER_WIDTH-1:0] user,
                              input logic [DATA_WIDTH-1:0] data);
        op_t                   op;
        sel_t                  sel;
        int                    unit;
        logic [DATA_WIDTH-1:0] value;
        op    = op_t'(user[1:0]);
        unit  = int'(user[3:2]);
        sel   = sel_t'(user[5:4]);
        value = '0;
        if (op == OP_TICK)
        begin
            tick_timers();
        end
        else if (op == OP_READ)
        begin
            if (unit < NUM_TIMERS)
            begin
                if (sel == SEL_CNTL)
                    value = ctrl_word[unit];
                else if (sel == SEL_LOAD)
                    value = DATA_WIDTH'(reload_val[unit]);
                else if (sel == SEL_COUNT)
                    value = DATA_WIDTH'(count_now[unit]);
            end
            due_read_data.push_back(value);
        end
        else if (op == OP_WRITE)
        begin
            if (unit < NUM_TIMERS)
            begin
                if (sel == SEL_CNTL)
                    write_control(unit, data);
                else if (sel == SEL_LOAD)
                    reload_val[unit] = data[COUNT_WIDTH-1:0];
            end
            due_read_data.push_back(data);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [DATA_WIDTH-1:0] want;
        if (!rst_n)
        begin
            clear_timers();
            due_read_data.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_read_data.size() == 0)
                begin
                    report_mismatch($sformatf("read_data %h with nothing expected",
                                              m_axis_tdata));
                end
                else
                begin
                    want = due_read_data.pop_front();
                    checked_total++;
                    if (m_axis_tdata !== want)
                        report_mismatch($sformatf("read_data %h, expected %h",
                                                  m_axis_tdata, want));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                apply_item(s_axis_tuser, s_axis_tdata);
        end
        mismatches      <= error_total;
        pending         <= due_read_data.size();
        results_checked <= checked_total;
    end

endmodule

>>> dv/testbench.sv
// testbench top: drives timer register items and gives the verdict
module testbench;

    import tmr3_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [1:0] SEL_UNUSED  = 2'd3;
    localparam logic [1:0] UNIT_ABSENT = 2'd3;
    localparam int         RANDOM_ITEMS = 650;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // write_data
    logic [DATA_WIDTH-1:0] s_axis_tdata = '0;
    // op [1:0], unit_index [3:2], reg_select [5:4]
    logic [USER_WIDTH-1:0] s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // read_data
    logic [DATA_WIDTH-1:0] m_axis_tdata;

    int   mismatches;
    int   pending;
    int   results_checked;
    logic steady = 1'b0;
    int   items_sent = 0;
    int   ticks_sent = 0;

    three_channel_reload_down_timer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    timer_register_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("timeout with %0d results outstanding", pending);
        $display("FAIL three_channel_reload_down_timer_unit");
        $finish;
    end

    // output side back-pressure
    initial
    begin
        forever
        begin
            @(posedge clk);
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 9);
        end
    end

    task automatic send_item(input logic [1:0] op_code, input logic [1:0] unit,
                             input logic [1:0] sel, input logic [DATA_WIDTH-1:0] data);
        if (!steady)
        begin
            while ($urandom_range(0, 99) < 9)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {sel, unit, op_code};
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (op_code == OP_TICK)
            ticks_sent++;
    endtask

    initial
    begin
        int                    pick;
        int                    drain;
        logic [1:0]            unit;
        logic [1:0]            sel;
        logic [DATA_WIDTH-1:0] load;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, wrap on zero load, one-shot end, ignored accesses
        send_item(OP_WRITE, 2'd0, SEL_LOAD, 32'hFFFF_FFFF);
        send_item(OP_READ, 2'd0, SEL_LOAD, 32'h0);
        send_item(OP_WRITE, 2'd2, SEL_LOAD, 32'd2);
        send_item(OP_WRITE, 2'd2, SEL_CNTL, 32'h0000_0001);
        send_item(OP_WRITE, 2'd1, SEL_CNTL, 32'h0000_0023);
        send_item(OP_TICK, 2'd0, SEL_CNTL, 32'h0);
        send_item(OP_TICK, 2'd0, SEL_CNTL, 32'h0);
        send_item(OP_TICK, 2'd0, SEL_CNTL, 32'h0);
        send_item(OP_READ, 2'd1, SEL_COUNT, 32'h0);
        send_item(OP_READ, 2'd2, SEL_COUNT, 32'h0);
        send_item(OP_READ, 2'd2, SEL_CNTL, 32'h0);
        send_item(OP_WRITE, 2'd0, SEL_CNTL, 32'hFFFF_FFFF);
        send_item(OP_READ, 2'd0, SEL_CNTL, 32'h0);
        send_item(OP_WRITE, 2'd0, SEL_COUNT, 32'h1234_5678);
        send_item(OP_READ, 2'd0, SEL_COUNT, 32'h0);
        send_item(OP_READ, UNIT_ABSENT, SEL_LOAD, 32'h0);
        send_item(OP_WRITE, UNIT_ABSENT, SEL_CNTL, 32'hFFFF_FFFF);
        send_item(OP_READ, 2'd0, SEL_UNUSED, 32'h0);
        send_item(OP_WRITE, 2'd0, SEL_UNUSED, 32'hA5A5_A5A5);
        send_item(OP_UNUSED, UNIT_ABSENT, SEL_UNUSED, 32'hFFFF_FFFF);
        send_item(OP_TICK, UNIT_ABSENT, SEL_UNUSED, 32'hFFFF_FFFF);
        send_item(OP_READ, 2'd0, SEL_COUNT, 32'h0);
        send_item(OP_WRITE, 2'd0, SEL_CNTL, 32'h0);
        send_item(OP_WRITE, 2'd1, SEL_CNTL, 32'h0000_0020);
        send_item(OP_READ, 2'd1, SEL_CNTL, 32'h0);

        // random: mostly ticks and control writes on small loads so counters hit zero
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 250 && n < 350);
            pick   = $urandom_range(0, 99);
            unit   = ($urandom_range(0, 19) == 0) ? UNIT_ABSENT
                                                  : 2'($urandom_range(0, NUM_TIMERS - 1));
            if (pick < 45)
            begin
                send_item(OP_TICK, 2'($urandom), 2'($urandom), $urandom());
            end
            else if (pick < 65)
            begin
                send_item(OP_READ, unit, 2'($urandom), $urandom());
            end
            else if (pick < 83)
            begin
                send_item(OP_WRITE, unit, SEL_CNTL, $urandom());
            end
            else if (pick < 93)
            begin
                load = ($urandom_range(0, 4) != 0) ? DATA_WIDTH'($urandom_range(0, 6))
                                                   : $urandom();
                send_item(OP_WRITE, unit, SEL_LOAD, load);
            end
            else if (pick < 97)
            begin
                sel = ($urandom_range(0, 1) != 0) ? 2'(SEL_COUNT) : SEL_UNUSED;
                send_item(OP_WRITE, unit, sel, $urandom());
            end
            else
            begin
                send_item(OP_UNUSED, 2'($urandom), 2'($urandom), $urandom());
            end
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        drain = 0;
        while (pending != 0 && drain < 5000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);

        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        $display("sent %0d items (%0d ticks), checked %0d register results",
                 items_sent, ticks_sent, results_checked);
        if (mismatches == 0 && pending == 0)
            $display("PASS three_channel_reload_down_timer_unit");
        else
            $display("FAIL three_channel_reload_down_timer_unit");
        $finish;
    end

endmodule
